// File: src/ifrf_pkg.sv
// ----------------------------------------------------------------------------
// Idle framed receive FIFO package
// Field widths, result kinds, input modes and fixed limits shared by the
// channel interfaces and the core.
// ----------------------------------------------------------------------------
package ifrf_pkg;

	localparam int MODE_W = 2;
	localparam int BYTE_W = 8;
	localparam int KIND_W = 3;
	localparam int LEN_W  = 6;
	localparam int TICK_W = 7;
	localparam int GAP_W  = 8;

	typedef logic [MODE_W-1:0] mode_t;
	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [KIND_W-1:0] kind_t;
	typedef logic [LEN_W-1:0]  len_t;
	typedef logic [TICK_W-1:0] tick_t;
	typedef logic [GAP_W-1:0]  gap_t;

	localparam mode_t MODE_BYTE  = 2'd0;
	localparam mode_t MODE_TICK  = 2'd1;
	localparam mode_t MODE_DRAIN = 2'd2;
	localparam mode_t MODE_RESET = 2'd3;

	localparam kind_t KIND_DATA      = 3'd0;
	localparam kind_t KIND_NODATA    = 3'd1;
	localparam kind_t KIND_DISCARDED = 3'd2;
	localparam kind_t KIND_QUIET     = 3'd3;
	localparam kind_t KIND_IDLE      = 3'd4;

	localparam gap_t  GAP_LIMIT        = 8'd100;
	localparam gap_t  GAP_DISARMED     = 8'hFF;
	localparam tick_t IDLE_TICKS_RESET = 7'd10;

endpackage

// File: src/ifrf_in_if.sv
// ----------------------------------------------------------------------------
// Idle framed receive FIFO input channel
// Valid/ready channel carrying one input word: mode, received byte, discard.
// ----------------------------------------------------------------------------
interface ifrf_in_if;

	logic           valid;
	logic           ready;
	ifrf_pkg::mode_t mode;
	ifrf_pkg::byte_t rx_byte;
	logic           discard;

	modport source (output valid, output mode, output rx_byte, output discard, input ready);
	modport sink   (input valid, input mode, input rx_byte, input discard, output ready);

endinterface

// File: src/ifrf_out_if.sv
// ----------------------------------------------------------------------------
// Idle framed receive FIFO result channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface ifrf_out_if;

	logic            valid;
	logic            ready;
	ifrf_pkg::kind_t result_kind;
	ifrf_pkg::byte_t data_byte;
	ifrf_pkg::len_t  packet_length;
	logic            last;

	modport source (output valid, output result_kind, output data_byte,
		output packet_length, output last, input ready);
	modport sink   (input valid, input result_kind, input data_byte,
		input packet_length, input last, output ready);

endinterface

// File: src/idle_framed_receive_fifo_core.sv
// ----------------------------------------------------------------------------
// Idle framed receive FIFO core
// Receive ring buffer framed by a quiet gap of timer ticks. Bytes are stored
// in a synchronous ring memory; a drain while idle streams or discards them.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake      | word
//  item     | in        | valid / ready  | mode, rx_byte, discard
//  result   | out       | valid / ready  | result_kind, data_byte, packet_length, last
//  cfg      | in        | cfg_we         | cfg_wdata (idle_ticks)
//
// A byte or a reset gives no result; a tick, or a drain that does not stream,
// gives one result word. A streamed drain reads each byte from the ring
// memory, then loads it into the output register, waiting while the result
// side stalls. No input word is taken while a drain streams. Reset
// clears the indices, idle flag and output valid flag and disarms the gap
// counter; the ring memory is not cleared.
// ----------------------------------------------------------------------------
module idle_framed_receive_fifo_core #(
	parameter int RING_DEPTH = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	ifrf_in_if.sink               item,
	ifrf_out_if.source            result,
	input  logic                  cfg_we,
	input  ifrf_pkg::tick_t       cfg_wdata
);

	localparam int IDX_W = $clog2(RING_DEPTH);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);
	localparam logic [IDX_W:0]   DEPTH_X  = (IDX_W + 1)'(RING_DEPTH);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RD   = 2'd1;
	localparam logic [1:0] ST_LD   = 2'd2;

	logic [1:0]            state_q;
	logic [IDX_W-1:0]      rd_idx_q;
	logic [IDX_W-1:0]      wr_idx_q;
	ifrf_pkg::gap_t        gap_q;
	logic                  idle_seen_q;
	ifrf_pkg::tick_t       idle_ticks_q;
	ifrf_pkg::len_t        len_q;
	ifrf_pkg::len_t        rem_q;

	ifrf_pkg::byte_t       ring_mem [RING_DEPTH];
	ifrf_pkg::byte_t       rd_data_q;

	logic                  out_valid_q;
	ifrf_pkg::kind_t       out_kind_q;
	ifrf_pkg::byte_t       out_data_q;
	ifrf_pkg::len_t        out_len_q;
	logic                  out_last_q;

	logic                  out_free;
	logic                  accept;
	logic                  mem_we;
	ifrf_pkg::gap_t        gap_inc;
	logic                  tick_fire;
	logic [IDX_W:0]        diff;
	ifrf_pkg::len_t        cur_len;
	logic                  has_data;
	logic [IDX_W-1:0]      rd_idx_next;
	logic                  ld_fire;
	logic                  stream_go;

	assign out_free    = !out_valid_q || result.ready;
	assign item.ready  = (state_q == ST_IDLE) && out_free;
	assign accept      = item.valid && item.ready;
	assign mem_we      = accept && (item.mode == ifrf_pkg::MODE_BYTE);
	assign ld_fire     = (state_q == ST_LD) && out_free;
	assign stream_go   = accept && (item.mode == ifrf_pkg::MODE_DRAIN) && has_data
		&& !item.discard;

	assign gap_inc     = (gap_q < ifrf_pkg::GAP_LIMIT) ? gap_q + 8'd1 : gap_q;
	assign tick_fire   = (ifrf_pkg::gap_t'(idle_ticks_q) <= gap_inc)
		&& (gap_inc <= ifrf_pkg::GAP_LIMIT);

	assign diff        = {1'b0, wr_idx_q} - {1'b0, rd_idx_q};
	assign cur_len     = (wr_idx_q >= rd_idx_q) ? ifrf_pkg::len_t'(diff)
		: ifrf_pkg::len_t'(diff + DEPTH_X);
	assign has_data    = idle_seen_q && (rd_idx_q != wr_idx_q);
	assign rd_idx_next = (rd_idx_q == LAST_IDX) ? '0 : rd_idx_q + 1'b1;

	assign result.valid         = out_valid_q;
	assign result.result_kind   = out_kind_q;
	assign result.data_byte     = out_data_q;
	assign result.packet_length = out_len_q;
	assign result.last          = out_last_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			ring_mem[wr_idx_q] <= item.rx_byte;
		end
		if (state_q == ST_RD) begin
			rd_data_q <= ring_mem[rd_idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_ticks_q <= ifrf_pkg::IDLE_TICKS_RESET;
		end else if (cfg_we) begin
			idle_ticks_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_idx_q    <= '0;
			wr_idx_q    <= '0;
			gap_q       <= ifrf_pkg::GAP_DISARMED;
			idle_seen_q <= 1'b0;
			len_q       <= '0;
			rem_q       <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (item.mode)
							ifrf_pkg::MODE_BYTE: begin
								gap_q    <= '0;
								wr_idx_q <= (wr_idx_q == LAST_IDX) ? '0 : wr_idx_q + 1'b1;
							end
							ifrf_pkg::MODE_TICK: begin
								if (tick_fire) begin
									idle_seen_q <= 1'b1;
									gap_q       <= ifrf_pkg::GAP_DISARMED;
								end else begin
									gap_q <= gap_inc;
								end
							end
							ifrf_pkg::MODE_RESET: begin
								gap_q       <= ifrf_pkg::GAP_DISARMED;
								rd_idx_q    <= '0;
								wr_idx_q    <= '0;
								idle_seen_q <= 1'b0;
							end
							default: begin
								idle_seen_q <= 1'b0;
								if (has_data) begin
									if (item.discard) begin
										rd_idx_q <= wr_idx_q;
									end else begin
										len_q   <= cur_len;
										rem_q   <= cur_len;
										state_q <= ST_RD;
									end
								end
							end
						endcase
					end
				end
				ST_RD: begin
					rd_idx_q <= rd_idx_next;
					state_q  <= ST_LD;
				end
				ST_LD: begin
					if (out_free) begin
						rem_q   <= rem_q - 1'b1;
						state_q <= (rem_q == 6'd1) ? ST_IDLE : ST_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ld_fire || (accept && !stream_go && (item.mode == ifrf_pkg::MODE_TICK
				|| item.mode == ifrf_pkg::MODE_DRAIN))) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_fire) begin
			out_kind_q <= ifrf_pkg::KIND_DATA;
			out_data_q <= rd_data_q;
			out_len_q  <= len_q;
			out_last_q <= (rem_q == 6'd1);
		end else if (accept) begin
			out_data_q <= '0;
			out_last_q <= 1'b1;
			out_len_q  <= '0;
			if (item.mode == ifrf_pkg::MODE_TICK) begin
				out_kind_q <= tick_fire ? ifrf_pkg::KIND_IDLE : ifrf_pkg::KIND_QUIET;
			end else if (has_data && item.discard) begin
				out_kind_q <= ifrf_pkg::KIND_DISCARDED;
				out_len_q  <= cur_len;
			end else begin
				out_kind_q <= ifrf_pkg::KIND_NODATA;
			end
		end
	end

	a_no_take_while_stream: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !item.ready)
		else $error("input word taken while a drain streams");

	a_tick_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.mode == ifrf_pkg::MODE_TICK) |=> result.valid)
		else $error("tick gave no result");

	a_drain_clears_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.mode == ifrf_pkg::MODE_DRAIN) |=> !idle_seen_q)
		else $error("idle flag not cleared by a drain");

	a_index_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_idx_q <= LAST_IDX) && (wr_idx_q <= LAST_IDX))
		else $error("ring index beyond depth");

	a_stream_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD || state_q == ST_LD) |-> (rem_q != 6'd0 && rem_q <= len_q))
		else $error("stream byte count out of range");

endmodule

// File: test/ifrf_receive_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Idle framed receive FIFO checker
// Follows every word accepted on the input channel and every write of the
// quiet-tick register, works out the result words that the receive buffer
// owes, and compares each word accepted on the result channel with the
// oldest one owed, field by field.
// ----------------------------------------------------------------------------
module ifrf_receive_checker #(
	parameter int RING_DEPTH = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	ifrf_in_if              item,
	ifrf_out_if             result,
	input  logic            cfg_we,
	input  ifrf_pkg::tick_t cfg_wdata,
	output int              failures,
	output int              pending,
	output int              checked,
	output int              idle_events,
	output int              streamed,
	output int              dropped,
	output int              empty_drains
);

	typedef struct packed {
		ifrf_pkg::kind_t kind;
		ifrf_pkg::byte_t data;
		ifrf_pkg::len_t  len;
		logic            last;
	} result_word_t;

	result_word_t    due_words[$];
	ifrf_pkg::byte_t ring [RING_DEPTH];
	int              rd_ptr;
	int              wr_ptr;
	ifrf_pkg::gap_t  gap;
	logic            idle_flag;
	ifrf_pkg::tick_t quiet_ticks;

	task automatic flag_mismatch(input string msg);
		failures++;
		$display("%0t: %s", $time, msg);
	endtask

	task automatic owe_word(input ifrf_pkg::kind_t k, input ifrf_pkg::byte_t d,
			input ifrf_pkg::len_t l, input logic z);
		result_word_t w;
		w.kind = k;
		w.data = d;
		w.len  = l;
		w.last = z;
		due_words.push_back(w);
	endtask

	task automatic model_receive_word(input ifrf_pkg::mode_t m, input ifrf_pkg::byte_t b,
			input logic drop);
		int span;
		int i;
		case (m)
		ifrf_pkg::MODE_BYTE: begin
			ring[wr_ptr] = b;
			gap = '0;
			wr_ptr = (wr_ptr + 1) % RING_DEPTH;
		end
		ifrf_pkg::MODE_TICK: begin
			if (gap < ifrf_pkg::GAP_LIMIT) begin
				gap = gap + 1'b1;
			end
			if (gap >= quiet_ticks && gap <= ifrf_pkg::GAP_LIMIT) begin
				idle_flag = 1'b1;
				gap = ifrf_pkg::GAP_DISARMED;
				idle_events++;
				owe_word(ifrf_pkg::KIND_IDLE, '0, '0, 1'b1);
			end else begin
				owe_word(ifrf_pkg::KIND_QUIET, '0, '0, 1'b1);
			end
		end
		ifrf_pkg::MODE_RESET: begin
			gap = ifrf_pkg::GAP_DISARMED;
			rd_ptr = 0;
			wr_ptr = 0;
			idle_flag = 1'b0;
		end
		default: begin
			if (!idle_flag || rd_ptr == wr_ptr) begin
				idle_flag = 1'b0;
				empty_drains++;
				owe_word(ifrf_pkg::KIND_NODATA, '0, '0, 1'b1);
			end else begin
				idle_flag = 1'b0;
				span = wr_ptr - rd_ptr;
				if (span < 0) begin
					span += RING_DEPTH;
				end
				if (drop) begin
					rd_ptr = wr_ptr;
					dropped++;
					owe_word(ifrf_pkg::KIND_DISCARDED, '0, ifrf_pkg::len_t'(span), 1'b1);
				end else begin
					for (i = 0; i < span; i++) begin
						owe_word(ifrf_pkg::KIND_DATA, ring[rd_ptr], ifrf_pkg::len_t'(span),
							i == span - 1);
						rd_ptr = (rd_ptr + 1) % RING_DEPTH;
					end
					streamed++;
				end
			end
		end
		endcase
	endtask

	task automatic check_result_word();
		result_word_t want;
		checked++;
		if (due_words.size() == 0) begin
			flag_mismatch($sformatf("result word %0d arrived with nothing owed", checked));
		end else begin
			want = due_words.pop_front();
			if (result.result_kind !== want.kind) begin
				flag_mismatch($sformatf("result word %0d: kind %0d, expected %0d",
					checked, result.result_kind, want.kind));
			end
			if (result.data_byte !== want.data) begin
				flag_mismatch($sformatf("result word %0d: data_byte %0h, expected %0h",
					checked, result.data_byte, want.data));
			end
			if (result.packet_length !== want.len) begin
				flag_mismatch($sformatf("result word %0d: packet_length %0d, expected %0d",
					checked, result.packet_length, want.len));
			end
			if (result.last !== want.last) begin
				flag_mismatch($sformatf("result word %0d: last %0b, expected %0b",
					checked, result.last, want.last));
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			due_words.delete();
			rd_ptr = 0;
			wr_ptr = 0;
			gap = ifrf_pkg::GAP_DISARMED;
			idle_flag = 1'b0;
			quiet_ticks = ifrf_pkg::IDLE_TICKS_RESET;
			failures = 0;
			pending = 0;
			checked = 0;
			idle_events = 0;
			streamed = 0;
			dropped = 0;
			empty_drains = 0;
		end else begin
			if (item.valid && item.ready) begin
				model_receive_word(item.mode, item.rx_byte, item.discard);
			end
			if (cfg_we) begin
				quiet_ticks = cfg_wdata;
			end
			if (result.valid && result.ready) begin
				check_result_word();
			end
			pending = due_words.size();
		end
	end

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Idle framed receive FIFO testbench
// Drives received bytes, ticks, drains and receive resets in bursts, with a
// changing stall pattern on the result side, across several quiet-tick
// settings including both extremes. A checker beside the core predicts and
// compares every result word; this module only makes stimulus and decides.
// ----------------------------------------------------------------------------
module tb;

	localparam int RING_DEPTH  = 64;
	localparam int CYCLE_LIMIT = 100000;
	localparam int PHASE_WORDS = 6;

	typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_PERIODIC} stall_style_t;

	logic            clk;
	logic            arst_n;
	logic            cfg_we;
	ifrf_pkg::tick_t cfg_wdata;
	int              failures;
	int              pending;
	int              checked;
	int              idle_events;
	int              streamed;
	int              dropped;
	int              empty_drains;
	int              words_sent;
	int              burst_left;
	int              cycles;
	int              settings_used;
	int              style_left;
	int              p;
	int              start;
	stall_style_t    stall_style;
	ifrf_pkg::tick_t quiet_now;
	ifrf_pkg::tick_t plan [2];

	ifrf_in_if  item_ch ();
	ifrf_out_if result_ch ();

	idle_framed_receive_fifo_core #(
		.RING_DEPTH (RING_DEPTH)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	ifrf_receive_checker #(
		.RING_DEPTH (RING_DEPTH)
	) CHK (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item_ch),
		.result       (result_ch),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.failures     (failures),
		.pending      (pending),
		.checked      (checked),
		.idle_events  (idle_events),
		.streamed     (streamed),
		.dropped      (dropped),
		.empty_drains (empty_drains)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		result_ch.ready = 1'b0;
		style_left = 0;
		forever begin
			@(negedge clk);
			if (style_left == 0) begin
				stall_style = stall_style_t'($urandom_range(0, 3));
				style_left = $urandom_range(40, 300);
			end
			style_left--;
			case (stall_style)
			READY_ALWAYS: result_ch.ready <= 1'b1;
			READY_COIN: result_ch.ready <= 1'($urandom_range(0, 1));
			READY_SPARSE: result_ch.ready <= ($urandom_range(0, 3) == 0);
			default: result_ch.ready <= (cycles % 5 != 0);
			endcase
		end
	end

	task automatic send_word(input ifrf_pkg::mode_t m, input ifrf_pkg::byte_t b,
			input logic d);
		int gap_len;
		if (burst_left == 0) begin
			gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap_len > 0) begin
				@(negedge clk);
				item_ch.valid <= 1'b0;
				repeat (gap_len - 1) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 16);
		end
		@(negedge clk);
		item_ch.valid   <= 1'b1;
		item_ch.mode    <= m;
		item_ch.rx_byte <= b;
		item_ch.discard <= d;
		do @(posedge clk); while (!item_ch.ready);
		burst_left--;
		words_sent++;
	endtask

	task automatic send_packet(input int bytes_n, input int ticks_n, input logic drop,
			input logic abort);
		int i;
		for (i = 0; i < bytes_n; i++) begin
			send_word(ifrf_pkg::MODE_BYTE, ifrf_pkg::byte_t'($urandom),
				1'($urandom_range(0, 1)));
		end
		for (i = 0; i < ticks_n; i++) begin
			send_word(ifrf_pkg::MODE_TICK, ifrf_pkg::byte_t'($urandom),
				1'($urandom_range(0, 1)));
		end
		if (abort) begin
			send_word(ifrf_pkg::MODE_RESET, ifrf_pkg::byte_t'($urandom),
				1'($urandom_range(0, 1)));
		end
		send_word(ifrf_pkg::MODE_DRAIN, ifrf_pkg::byte_t'($urandom), drop);
	endtask

	task automatic settle();
		@(negedge clk);
		item_ch.valid <= 1'b0;
		burst_left = 0;
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_quiet_ticks(input ifrf_pkg::tick_t v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
		quiet_now = v;
		settings_used++;
	endtask

	function automatic int ticks_to_idle();
		if (quiet_now == 0) begin
			return 1;
		end else if (quiet_now <= ifrf_pkg::GAP_LIMIT) begin
			return quiet_now;
		end
		return $urandom_range(0, 5);
	endfunction

	function automatic int packet_size();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			return 0;
		end
		return $urandom_range(1, 5);
	endfunction

	task automatic random_step();
		int pick;
		int need;
		need = ticks_to_idle();
		pick = $urandom_range(0, 19);
		if (pick == 0) begin
			settle();
		end else if (pick <= 12) begin
			send_packet(packet_size(), need + $urandom_range(0, 1),
				$urandom_range(0, 3) == 0, 1'b0);
		end else if (pick <= 14) begin
			send_packet(packet_size(), (need > 0) ? $urandom_range(0, need - 1) : 0,
				1'($urandom_range(0, 1)), 1'b0);
		end else if (pick <= 16) begin
			send_packet(packet_size(), need, 1'($urandom_range(0, 1)), 1'b1);
		end else begin
			send_word(ifrf_pkg::mode_t'($urandom_range(0, 3)), ifrf_pkg::byte_t'($urandom),
				1'($urandom_range(0, 1)));
		end
	endtask

	initial begin
		item_ch.valid   = 1'b0;
		item_ch.mode    = ifrf_pkg::MODE_BYTE;
		item_ch.rx_byte = '0;
		item_ch.discard = 1'b0;
		cfg_we          = 1'b0;
		cfg_wdata       = '0;
		arst_n          = 1'b0;
		burst_left      = 0;
		words_sent      = 0;
		settings_used   = 1;
		quiet_now       = ifrf_pkg::IDLE_TICKS_RESET;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_word(ifrf_pkg::MODE_DRAIN, 8'h00, 1'b0);
		send_word(ifrf_pkg::MODE_TICK, 8'hFF, 1'b1);
		send_word(ifrf_pkg::MODE_RESET, 8'h00, 1'b0);
		settle();
		write_quiet_ticks(7'd1);
		send_word(ifrf_pkg::MODE_BYTE, 8'h00, 1'b0);
		send_word(ifrf_pkg::MODE_BYTE, 8'hFF, 1'b1);
		send_word(ifrf_pkg::MODE_BYTE, 8'hA5, 1'b0);
		send_word(ifrf_pkg::MODE_TICK, 8'h00, 1'b0);
		send_word(ifrf_pkg::MODE_DRAIN, 8'h00, 1'b0);
		send_word(ifrf_pkg::MODE_DRAIN, 8'h00, 1'b1);
		send_word(ifrf_pkg::MODE_BYTE, 8'h5A, 1'b0);
		send_word(ifrf_pkg::MODE_TICK, 8'h00, 1'b0);
		send_word(ifrf_pkg::MODE_DRAIN, 8'h00, 1'b1);
		send_word(ifrf_pkg::MODE_BYTE, 8'h3C, 1'b0);
		send_word(ifrf_pkg::MODE_TICK, 8'h00, 1'b0);
		send_word(ifrf_pkg::MODE_RESET, 8'h00, 1'b0);
		send_word(ifrf_pkg::MODE_DRAIN, 8'h00, 1'b0);
		settle();
		write_quiet_ticks(7'd0);
		send_word(ifrf_pkg::MODE_BYTE, 8'h81, 1'b0);
		send_word(ifrf_pkg::MODE_TICK, 8'h00, 1'b0);
		send_word(ifrf_pkg::MODE_DRAIN, 8'h00, 1'b0);
		settle();
		write_quiet_ticks(7'd127);
		send_word(ifrf_pkg::MODE_BYTE, 8'h7E, 1'b0);
		send_word(ifrf_pkg::MODE_TICK, 8'h00, 1'b0);
		send_word(ifrf_pkg::MODE_TICK, 8'h00, 1'b0);
		send_word(ifrf_pkg::MODE_DRAIN, 8'h00, 1'b0);

		settle();
		write_quiet_ticks(7'd1);
		// A long packet leaves the read index near the top of the ring, so the
		// next packet wraps round the end of the memory.
		send_word(ifrf_pkg::MODE_RESET, 8'h00, 1'b0);
		send_packet(62, 1, 1'b0, 1'b0);
		send_packet(6, 1, 1'b0, 1'b0);

		plan[0] = 7'd2;
		plan[1] = ifrf_pkg::tick_t'($urandom_range(3, 5));
		for (p = 0; p < 2; p++) begin
			settle();
			write_quiet_ticks(plan[p]);
			start = words_sent;
			while (words_sent - start < PHASE_WORDS) begin
				random_step();
			end
		end

		settle();
		repeat (24) @(negedge clk);
		$display("Covered %0d input words across %0d quiet-tick settings, 0 and 127 included.",
			words_sent, settings_used);
		$display("%0d result words checked: %0d idle events, %0d packets streamed,",
			checked, idle_events, streamed);
		$display("%0d packets discarded and %0d no-data replies.", dropped, empty_drains);
		if (failures == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
